// ===== hdl/pip_pkg.sv =====
// Package for the point-in-polygon tester: sizes, function codes, FSM states
// and the command/status structs shared by controller and datapath.
// No dependencies.
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_WIDTH  = 16;
	localparam int MIN_POLY     = 3;

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} pip_state_t;

	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic             rd_prime;
		logic [IDX_W-1:0] rd_addr;
		logic             load_out;
	} pip_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
	} pip_stat_t;

endpackage

// ===== hdl/point_in_polygon_test.sv =====
// Top level of the crossing-number point-in-polygon tester.
// Instantiates pip_ctrl and pip_dp; depends on pip_pkg.
//
// Items either clear the polygon, append a vertex (up to 64; further appends
// are dropped and set a sticky overflow flag) or query a point. Clear and
// append give no result. A query on n >= 3 stored vertices reads the last
// vertex, then walks from the first: the vertex memory has one read port and
// the walk reads one vertex per cycle, followed by a three-stage edge test
// (difference, multiply, compare). A query on fewer than three vertices skips
// the walk. Each query gives one result transfer; the result sits in an
// output register so further clears and appends are taken while it waits.
module point_in_polygon_test (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             func,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   inside_res,
	output logic                                   polygon_valid,
	output logic                                   overflowed
);
	import pip_pkg::*;

	pip_cmd_t  cmd;
	pip_stat_t stat;

	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pip_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.cmd           (cmd),
		.stat          (stat),
		.inside_res    (inside_res),
		.polygon_valid (polygon_valid),
		.overflowed    (overflowed)
	);

endmodule

// ===== hdl/pip_ctrl.sv =====
// Controller FSM for the point-in-polygon tester: sequences the vertex walk
// and owns the handshakes. Depends on pip_pkg.
module pip_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	output logic               out_valid,
	input  logic               out_ready,
	input  pip_pkg::pip_stat_t stat,
	output pip_pkg::pip_cmd_t  cmd
);
	import pip_pkg::*;

	pip_state_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             last_idx;
	logic             out_free;
	logic             accept;
	logic             enough;

	assign accept   = in_valid && in_ready;
	assign last_idx = (CNT_W'(idx_q) == (stat.count - CNT_W'(1)));
	assign out_free = !out_valid_q || out_ready;
	assign enough   = (stat.count >= CNT_W'(MIN_POLY));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_QUERY)
					state_d = enough ? ST_PRIME : ST_RESULT;
			end
			ST_PRIME:  state_d = ST_WALK;
			ST_WALK: begin
				if (last_idx)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = accept;
		cmd.rd_en    = 1'b0;
		cmd.rd_prime = 1'b0;
		cmd.rd_addr  = idx_q;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_PRIME: begin
				// closing edge starts at the last stored vertex
				cmd.rd_en    = 1'b1;
				cmd.rd_prime = 1'b1;
				cmd.rd_addr  = IDX_W'(stat.count - CNT_W'(1));
			end
			ST_WALK:   cmd.rd_en = 1'b1;
			ST_DRAIN:  ;
			ST_RESULT: cmd.load_out = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PRIME)
				idx_q <= '0;
			else if (state_q == ST_WALK)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/pip_dp.sv =====
// Datapath for the point-in-polygon tester: vertex memories, vertex count,
// overflow flag, three-stage edge test and result register. Depends on pip_pkg.
module pip_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [1:0]                           func,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
	input  pip_pkg::pip_cmd_t                    cmd,
	output pip_pkg::pip_stat_t                   stat,
	output logic                                 inside_res,
	output logic                                 polygon_valid,
	output logic                                 overflowed
);
	import pip_pkg::*;

	logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

	logic [CNT_W-1:0]              count_q;
	logic                          ovf_q;
	logic                          wr_en;
	logic signed [COORD_WIDTH-1:0] px_q, py_q;
	logic signed [COORD_WIDTH-1:0] rdx_q, rdy_q;
	logic                          rdv_q, prime_q;
	logic signed [COORD_WIDTH-1:0] xo_q, yo_q;

	logic                          straddle, swap;
	logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2;
	logic signed [DIFF_W-1:0]      da, db, dc, dd;

	logic                          v_s1, str_s1;
	logic signed [DIFF_W-1:0]      da_s1, db_s1, dc_s1, dd_s1;
	logic                          v_s2, str_s2;
	logic signed [PROD_W-1:0]      pl_s2, pr_s2;
	logic                          inside_q;

	assign wr_en = cmd.accept && func == FUNC_APPEND &&
		count_q < CNT_W'(MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[count_q[IDX_W-1:0]] <= coord_x;
			mem_y[count_q[IDX_W-1:0]] <= coord_y;
		end
		if (cmd.rd_en) begin
			rdx_q <= mem_x[cmd.rd_addr];
			rdy_q <= mem_y[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			rdv_q   <= 1'b0;
			prime_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cmd.accept && func == FUNC_CLEAR) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.accept && func == FUNC_APPEND) begin
				if (wr_en)
					count_q <= count_q + CNT_W'(1);
				else
					ovf_q <= 1'b1;
			end
			rdv_q   <= cmd.rd_en;
			prime_q <= cmd.rd_prime;
			v_s1    <= rdv_q && !prime_q;
			v_s2    <= v_s1;
		end
	end

	// edge from previous vertex (xo, yo) to the one just read
	always_comb begin
		straddle = ((rdx_q < px_q) == (px_q <= xo_q));
		swap     = (rdx_q > xo_q);
		x1 = swap ? xo_q : rdx_q;
		y1 = swap ? yo_q : rdy_q;
		x2 = swap ? rdx_q : xo_q;
		y2 = swap ? rdy_q : yo_q;
		da = DIFF_W'(py_q) - DIFF_W'(y1);
		db = DIFF_W'(x2) - DIFF_W'(x1);
		dc = DIFF_W'(y2) - DIFF_W'(y1);
		dd = DIFF_W'(px_q) - DIFF_W'(x1);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && func == FUNC_QUERY) begin
			px_q     <= coord_x;
			py_q     <= coord_y;
			inside_q <= 1'b0;
		end else if (v_s2 && str_s2 && (pl_s2 < pr_s2)) begin
			inside_q <= ~inside_q;
		end
		if (rdv_q) begin
			xo_q <= rdx_q;
			yo_q <= rdy_q;
		end
		str_s1 <= straddle;
		da_s1  <= da;
		db_s1  <= db;
		dc_s1  <= dc;
		dd_s1  <= dd;
		str_s2 <= str_s1;
		// operands sign-extended first so the full product is kept
		pl_s2  <= PROD_W'(da_s1) * PROD_W'(db_s1);
		pr_s2  <= PROD_W'(dc_s1) * PROD_W'(dd_s1);
		if (cmd.load_out) begin
			inside_res    <= inside_q;
			polygon_valid <= (count_q >= CNT_W'(MIN_POLY));
			overflowed    <= ovf_q;
		end
	end

	assign stat.count = count_q;
	assign stat.busy  = rdv_q || v_s1 || v_s2;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for point_in_polygon_test: drives clear/append/query
// transfers, predicts each query answer by crossing parity and compares them.
// Depends on pip_pkg and the point_in_polygon_test RTL.
module tb_top;
	import pip_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;	// unused code, block ignores it
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_ITEMS   = 160;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef struct packed {
		logic in_poly;
		logic poly_ok;
		logic ovf;
	} answer_t;

	localparam coord_t C_MAX = coord_t'(2 ** (COORD_WIDTH - 1) - 1);
	localparam coord_t C_MIN = coord_t'(-(2 ** (COORD_WIDTH - 1)));

	class crossing_tracker;
		coord_t  vx[MAX_VERTICES];
		coord_t  vy[MAX_VERTICES];
		int      n_stored;
		bit      dropped;
		answer_t pending[$];
		int      errors;
		int      answers;
		int      hits;
		int      ovf_seen;

		// walk the closed outline, last vertex to first, toggling on each crossed edge
		function logic crossing_parity(longint px, longint py);
			longint xo, yo, xn, yn, x1, y1, x2, y2;
			logic   odd;
			odd = 1'b0;
			if (n_stored < MIN_POLY)
				return 1'b0;
			xo = vx[n_stored - 1];
			yo = vy[n_stored - 1];
			for (int i = 0; i < n_stored; i++) begin
				xn = vx[i];
				yn = vy[i];
				if (xn > xo) begin
					x1 = xo; y1 = yo; x2 = xn; y2 = yn;
				end else begin
					x1 = xn; y1 = yn; x2 = xo; y2 = yo;
				end
				// half-open x span, then exact cross-multiplied side test
				if (((xn < px) == (px <= xo)) &&
						((py - y1) * (x2 - x1) < (y2 - y1) * (px - x1)))
					odd = ~odd;
				xo = xn;
				yo = yn;
			end
			return odd;
		endfunction

		function void take_item(logic [1:0] f, coord_t x, coord_t y);
			answer_t a;
			case (f)
				FUNC_CLEAR: begin
					n_stored = 0;
					dropped  = 1'b0;
				end
				FUNC_APPEND: begin
					if (n_stored < MAX_VERTICES) begin
						vx[n_stored] = x;
						vy[n_stored] = y;
						n_stored++;
					end else begin
						dropped = 1'b1;
					end
				end
				FUNC_QUERY: begin
					a.in_poly = crossing_parity(x, y);
					a.poly_ok = (n_stored >= MIN_POLY);
					a.ovf     = dropped;
					pending.push_back(a);
				end
				default: ;
			endcase
		endfunction

		function void check_answer(logic ins, logic ok, logic ovf);
			answer_t want;
			if (pending.size() == 0) begin
				$error("result transfer with no query outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			answers++;
			if (want.in_poly)
				hits++;
			if (want.ovf)
				ovf_seen++;
			if (ins !== want.in_poly) begin
				$error("inside_res: expected %0b, got %0b", want.in_poly, ins);
				errors++;
			end
			if (ok !== want.poly_ok) begin
				$error("polygon_valid: expected %0b, got %0b", want.poly_ok, ok);
				errors++;
			end
			if (ovf !== want.ovf) begin
				$error("overflowed: expected %0b, got %0b", want.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] func;
	coord_t     coord_x;
	coord_t     coord_y;
	logic       out_valid;
	logic       out_ready;
	logic       inside_res;
	logic       polygon_valid;
	logic       overflowed;

	crossing_tracker tracker = new;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit long_hold      = 1'b0;
	int quiet_cycles   = 0;
	int items_sent     = 0;

	point_in_polygon_test uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inside_res   (inside_res),
		.polygon_valid(polygon_valid),
		.overflowed   (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// transfer monitor: feeds the predictor and checks answers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.take_item(func, coord_x, coord_y);
			if (out_valid && out_ready)
				tracker.check_answer(inside_res, polygon_valid, overflowed);
			quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
				0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin : receiver
		int held;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
				long_hold = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(logic [1:0] f, coord_t x, coord_t y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		coord_x  <= x;
		coord_y  <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (f != FUNC_SPARE)
			items_sent++;
	endtask

	function automatic coord_t spread(int span);
		return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
	endfunction

	// build one outline (optionally on top of the old one), then query it
	task automatic run_shape(int n, int q, bit keep);
		coord_t sx[$];
		coord_t sy[$];
		coord_t px, py;
		int     span, pick;
		case ($urandom_range(3))
			0: span = 8;
			1: span = 64;
			2: span = 2048;
			default: span = 32768;
		endcase
		if (!keep)
			send_item(FUNC_CLEAR, spread(32768), spread(32768));
		repeat (n) begin
			px = spread(span);
			py = spread(span);
			if ($urandom_range(19) == 0)
				px = $urandom_range(1) ? C_MAX : C_MIN;
			if ($urandom_range(19) == 0)
				py = $urandom_range(1) ? C_MAX : C_MIN;
			sx.push_back(px);
			sy.push_back(py);
			send_item(FUNC_APPEND, px, py);
			if ($urandom_range(29) == 0)
				send_item(FUNC_SPARE, spread(32768), spread(32768));
		end
		repeat (q) begin
			pick = $urandom_range(9);
			px = spread(span);
			py = spread(span);
			if (pick < 4 && sx.size() > 0) begin
				// land on vertex coordinates to hit the span ends and ties
				px = sx[$urandom_range(sx.size() - 1)];
				if (pick < 2)
					py = sy[$urandom_range(sy.size() - 1)];
			end else if (pick == 9) begin
				px = spread(32768);
				py = spread(32768);
			end
			send_item(FUNC_QUERY, px, py);
		end
	endtask

	task automatic run_random_shape();
		int r, n;
		r = $urandom_range(99);
		if (r < 10)
			n = $urandom_range(2);
		else if (r < 15)
			n = $urandom_range(55, 70);
		else
			n = $urandom_range(3, 12);
		run_shape(n, $urandom_range(2, 8), $urandom_range(9) == 0);
	endtask

	initial begin : stimulus
		int target;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = FUNC_CLEAR;
		coord_x  = '0;
		coord_y  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty, then two vertices (too few to form a polygon), then a triangle
		send_item(FUNC_CLEAR, 0, 0);
		send_item(FUNC_QUERY, 0, 0);
		send_item(FUNC_APPEND, 0, 0);
		send_item(FUNC_APPEND, 10, 0);
		send_item(FUNC_QUERY, 5, 1);
		send_item(FUNC_APPEND, 0, 10);
		send_item(FUNC_QUERY, 2, 2);
		send_item(FUNC_QUERY, 20, 20);
		send_item(FUNC_QUERY, 0, 5);
		send_item(FUNC_QUERY, 10, 0);
		send_item(FUNC_SPARE, C_MIN, C_MAX);
		// square on the corners of the coordinate range
		send_item(FUNC_CLEAR, C_MAX, C_MIN);
		send_item(FUNC_APPEND, C_MIN, C_MIN);
		send_item(FUNC_APPEND, C_MAX, C_MIN);
		send_item(FUNC_APPEND, C_MAX, C_MAX);
		send_item(FUNC_APPEND, C_MIN, C_MAX);
		send_item(FUNC_QUERY, 0, 0);
		send_item(FUNC_QUERY, C_MIN, C_MIN);
		send_item(FUNC_QUERY, C_MAX, C_MAX);
		send_item(FUNC_QUERY, -1, C_MAX);
		send_item(FUNC_QUERY, C_MAX, 0);

		// fill past capacity, then a clear must drop the overflow flag
		run_shape(MAX_VERTICES + 3, 3, 1'b0);
		send_item(FUNC_APPEND, 1, 1);
		send_item(FUNC_QUERY, 0, 0);
		send_item(FUNC_CLEAR, 0, 0);
		send_item(FUNC_QUERY, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				run_random_shape();
		end

		// output held off for a long stretch while queries keep coming
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		long_hold      = 1'b1;
		run_shape(6, 12, 1'b0);

		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items over idle, stall, mixed and long-hold phases, incl. a full store.",
			items_sent);
		$display("Checked %0d query answers: %0d inside, %0d with overflow set.",
			tracker.answers, tracker.hits, tracker.ovf_seen);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
